>>> hw/rtl/ttng_pkg.sv
// Shared types, constants and the sine quarter-wave table of the test tone and noise generator.
package ttng_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W            = IDX_W - 2;
    localparam int TI_W             = QTR_W + 1;
    localparam int MAX_CHANNELS     = 8;
    localparam int SAMPLE_BITS      = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int CNT_W            = 4;
    localparam int WORK_W           = 34;

    localparam logic [31:0] LCG_MUL        = 32'd1103515245;
    localparam logic [31:0] LCG_INC        = 32'd12345;
    localparam logic [15:0] NOISE_FULL     = 16'd32767;
    localparam logic [15:0] NOISE_HALF     = 16'd16383;
    localparam logic [31:0] NOISE_SEED_RST = 32'd1;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_STEP   = 3'd1;
    localparam logic [2:0] CFG_AMP    = 3'd2;
    localparam logic [2:0] CFG_COUNT  = 3'd3;
    localparam logic [2:0] CFG_PAUSED = 3'd4;
    localparam logic [2:0] CFG_SEED   = 3'd5;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FEW    = 2'd1;
    localparam logic [1:0] STAT_PAUSED = 2'd2;

    typedef enum logic [1:0] {
        MODE_SINE    = 2'd0,
        MODE_SQUARE  = 2'd1,
        MODE_NOISE   = 2'd2,
        MODE_SILENCE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_STATUS,
        OP_SINE,
        OP_SQUARE,
        OP_NOISE,
        OP_SILENCE
    } t_op;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] phase_step;
        logic [23:0] amplitude;
        logic [3:0]  channel_count;
        logic        paused;
        logic [31:0] noise_seed;
    } t_cfg;

    typedef struct packed {
        logic [3:0] available_channels;
        logic       chunk_end;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] sample;
        logic [2:0]         channel;
        logic               last_of_frame;
        logic               end_of_chunk;
    } t_out;

    // One classified frame request, as queued between front and back.
    typedef struct packed {
        t_op             op;
        logic [1:0]      status;
        logic [CNT_W-1:0] count;
        logic            chunk_end;
        logic [TI_W-1:0] ti;
        logic            neg;
    } t_cmd;

    typedef logic [23:0] t_sine_rom [0:QUARTER];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    // Quarter-wave sine in Q1.23, built from a Q2.30 Taylor series at elaboration.
    function automatic t_sine_rom f_build_sine();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int i = 0; i <= QUARTER; i++) begin
            x    = (longint'(i) * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 0; k < 6; k++) begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[k];
                if (k % 2 == 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rom[i] = 24'((longint'(sum) + 64) >>> 7);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

endpackage

>>> hw/rtl/test_tone_noise_generator.sv
// Top level of the test tone and noise generator: configuration registers and block wiring.
//
// Each item on the input channel (i_in_valid / o_in_ready, payload i_in_data) requests
// one audio frame. The frame produces one result item per configured channel on the
// output channel (o_out_valid / i_out_ready, payload o_out_data), or a single status
// item when the destination has too few channels or the generator is paused.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must keep
// such writes to idle, as the block itself does not enforce it. Writing the noise seed
// reloads the noise generator at once. Throughput: one result per cycle while the
// receiver does not stall; a frame of N channels yields N results and a status frame
// one. The per-channel issue counter and the single output register set that rate.
// Accepted items pass the request queue, stages 1 and 2 and the output register.
// A four-entry request queue sits between the classifier and the sample pipeline, so
// new items are accepted while results wait. When the receiver stalls, the output
// register holds its item and the pipeline freezes; once the queue fills, o_in_ready
// drops.
// Reset (synchronous, active low) restores register defaults, clears the phase
// accumulator, empties the queue and reloads the noise state with seed 1.
module test_tone_noise_generator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ttng_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ttng_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);
    import ttng_pkg::*;

    t_cfg r_cfg;
    logic seed_load;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign seed_load = i_cfg_we && (i_cfg_idx == CFG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_SILENCE;
            r_cfg.phase_step    <= '0;
            r_cfg.amplitude     <= 24'd8388608;
            r_cfg.channel_count <= 4'd2;
            r_cfg.paused        <= 1'b0;
            r_cfg.noise_seed    <= NOISE_SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_cfg.mode          <= t_mode'(i_cfg_data[1:0]);
                CFG_STEP:   r_cfg.phase_step    <= i_cfg_data;
                CFG_AMP:    r_cfg.amplitude     <= i_cfg_data[23:0];
                CFG_COUNT:  r_cfg.channel_count <= i_cfg_data[3:0];
                CFG_PAUSED: r_cfg.paused        <= i_cfg_data[0];
                CFG_SEED:   r_cfg.noise_seed    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    ttng_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    ttng_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (cmd_out)
    );

    ttng_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_seed_load (seed_load),
        .i_seed      (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hw/rtl/ttng_queue.sv
// Short command queue that decouples frame classification from sample generation.
module ttng_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ttng_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ttng_pkg::t_cmd  o_data
);
    import ttng_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr;
    logic [QP_W-1:0] r_rd;
    logic [QP_W:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (QP_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/ttng_front.sv
// Front end: accepts frame requests, classifies them and owns the phase accumulator.
module ttng_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ttng_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ttng_pkg::t_in   i_in_data,
    input  logic            i_q_full,
    output logic            o_push,
    output ttng_pkg::t_cmd  o_cmd
);
    import ttng_pkg::*;

    logic [31:0]      r_phase;
    logic [31:0]      n_phase;
    logic [CNT_W-1:0] count;
    logic             few;
    logic [IDX_W-1:0] idx;
    logic [1:0]       quad;
    logic [TI_W-1:0]  rr;
    logic             tone_mode;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        if (i_cfg.channel_count == '0) begin
            count = CNT_W'(1);
        end else if (i_cfg.channel_count > CNT_W'(MAX_CHANNELS)) begin
            count = CNT_W'(MAX_CHANNELS);
        end else begin
            count = i_cfg.channel_count;
        end
    end

    assign few  = (i_in_data.available_channels < count);
    assign idx  = r_phase[31 -: IDX_W];
    assign quad = idx[IDX_W-1 -: 2];
    assign rr   = {1'b0, idx[QTR_W-1:0]};
    assign tone_mode = (i_cfg.mode == MODE_SINE) || (i_cfg.mode == MODE_SQUARE);

    always_comb begin
        o_cmd.count     = count;
        o_cmd.chunk_end = i_in_data.chunk_end;
        o_cmd.status    = STAT_OK;
        o_cmd.ti        = quad[0] ? (TI_W'(QUARTER) - rr) : rr;
        o_cmd.neg       = (i_cfg.mode == MODE_SQUARE) ? r_phase[31] : quad[1];
        // The channel check wins over pause.
        if (few || i_cfg.paused) begin
            o_cmd.op     = OP_STATUS;
            o_cmd.status = few ? STAT_FEW : STAT_PAUSED;
        end else begin
            unique case (i_cfg.mode)
                MODE_SINE:   o_cmd.op = OP_SINE;
                MODE_SQUARE: o_cmd.op = OP_SQUARE;
                MODE_NOISE:  o_cmd.op = OP_NOISE;
                default:     o_cmd.op = OP_SILENCE;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (o_push && !few && !i_cfg.paused && tone_mode) begin
            n_phase = r_phase + i_cfg.phase_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

>>> hw/rtl/ttng_back.sv
// Back end: issues one channel per cycle unless the output stalls; three pipeline stages compute samples.
module ttng_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ttng_pkg::t_cfg  i_cfg,
    input  logic            i_seed_load,
    input  logic [31:0]     i_seed,
    input  logic            i_q_valid,
    input  ttng_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ttng_pkg::t_out  o_out_data
);
    import ttng_pkg::*;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
        logic       neg;
        logic [2:0] channel;
        logic       last;
        logic       eoc;
    } t_tag;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic        en;
    logic        issue;
    logic        frame_last;
    logic [2:0]  r_emit;
    logic [31:0] r_noise;
    logic [31:0] noise_adv;

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    t_tag        r_tag1;
    t_tag        r_tag2;
    logic [23:0] r_tbl1;
    logic [14:0] r_rnd1;
    logic [47:0] r_prod2;
    t_out        r_out;

    t_tag        tag0;
    logic [15:0] centered;
    logic [23:0] factor;
    logic        noise_neg;

    logic [48:0] sine_round;
    logic [39:0] div_y;
    logic [25:0] div_s1;
    logic [15:0] div_s2;
    logic [25:0] noise_mag;
    logic [25:0] mag;
    logic signed [WORK_W-1:0] val;
    logic signed [WORK_W-1:0] sat;

    // The whole pipeline moves whenever the output register can take a result.
    assign en         = !r_v3 || i_out_ready;
    assign issue      = en && i_q_valid;
    assign frame_last = (i_cmd.op == OP_STATUS) ||
                        ({1'b0, r_emit} == (i_cmd.count - CNT_W'(1)));
    assign o_pop      = issue && frame_last;
    assign noise_adv  = r_noise * LCG_MUL + LCG_INC;

    always_comb begin
        tag0.op      = i_cmd.op;
        tag0.status  = i_cmd.status;
        tag0.neg     = i_cmd.neg;
        tag0.channel = r_emit;
        tag0.last    = frame_last;
        tag0.eoc     = frame_last && i_cmd.chunk_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit  <= '0;
            r_noise <= NOISE_SEED_RST;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (i_seed_load) begin
                r_noise <= i_seed;
            end else if (issue && i_cmd.op == OP_NOISE) begin
                r_noise <= noise_adv;
            end
            if (issue) begin
                r_emit <= frame_last ? '0 : r_emit + 1'b1;
            end
            if (en) begin
                r_v1 <= issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: table lookup and noise draw.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag1 <= tag0;
            r_tbl1 <= SINE_ROM[i_cmd.ti];
            r_rnd1 <= noise_adv[30:16];
        end
    end

    // Stage 2: center the noise draw and scale by the amplitude.
    always_comb begin
        if (r_rnd1[14]) begin
            centered  = {r_rnd1, 1'b0} - NOISE_FULL;
            noise_neg = 1'b0;
        end else begin
            centered  = NOISE_FULL - {r_rnd1, 1'b0};
            noise_neg = 1'b1;
        end
        factor = (r_tag1.op == OP_NOISE) ? {9'd0, centered[14:0]} : r_tbl1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag2.op      <= r_tag1.op;
            r_tag2.status  <= r_tag1.status;
            r_tag2.neg     <= (r_tag1.op == OP_NOISE) ? noise_neg : r_tag1.neg;
            r_tag2.channel <= r_tag1.channel;
            r_tag2.last    <= r_tag1.last;
            r_tag2.eoc     <= r_tag1.eoc;
            r_prod2        <= factor * i_cfg.amplitude;
        end
    end

    // Stage 3: rounding, division by 32767 via 2^15 = 1 (mod 32767), sign and saturation.
    always_comb begin
        sine_round = {1'b0, r_prod2} + 49'(1 << 22);
        div_y      = r_prod2[39:0] + 40'(NOISE_HALF);
        div_s1     = {1'b0, div_y[39:15]} + 26'(div_y[14:0]);
        div_s2     = {5'd0, div_s1[25:15]} + {1'b0, div_s1[14:0]};
        noise_mag  = div_y[39:15] + 26'(div_s1[25:15])
                   + 26'(div_s2 >= NOISE_FULL);
        case (r_tag2.op)
            OP_SINE:   mag = sine_round[48:23];
            OP_SQUARE: mag = 26'(i_cfg.amplitude);
            OP_NOISE:  mag = noise_mag;
            default:   mag = '0;
        endcase
        val = r_tag2.neg ? -$signed(WORK_W'(mag)) : $signed(WORK_W'(mag));
        if (val > $signed(WORK_W'(SAT_HI))) begin
            sat = $signed(WORK_W'(SAT_HI));
        end else if (val < $signed(WORK_W'(SAT_LO))) begin
            sat = $signed(WORK_W'(SAT_LO));
        end else begin
            sat = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.status        <= r_tag2.status;
            r_out.sample        <= sat[23:0];
            r_out.channel       <= r_tag2.channel;
            r_out.last_of_frame <= r_tag2.last;
            r_out.end_of_chunk  <= r_tag2.eoc;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

endmodule

>>> test/test_tone_noise_generator_test.sv
// Self-checking testbench for the test tone and noise generator.
module test_tone_noise_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttng_pkg::*;

    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam longint NOISE_SPAN  = 32767;
    localparam longint NOISE_ROUND = 16383;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 250;
    localparam int IDLE_PCT [4]    = '{0, 57, 0, 26};
    localparam int STALL_PCT [4]   = '{0, 0, 57, 26};

    typedef enum logic {
        ROW_WRITE,
        ROW_FRAME
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        t_in         req;
        logic        fixed;
        t_out        want;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_data  = '0;

    // Generator state as the testbench sees it.
    t_mode       gen_mode;
    logic [31:0] gen_step;
    logic [23:0] gen_amp;
    logic [3:0]  gen_count;
    logic        gen_paused;
    logic [31:0] phase_acc;
    logic [31:0] noise_state;
    logic [31:0] quarter_sine [0:QUARTER];

    t_out expected_results [$];
    int   mismatches    = 0;
    int   idle_pct      = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;
    logic long_hold_req = 1'b0;

    test_tone_noise_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic t_stim_row write_row(input logic [2:0] idx, input logic [31:0] val);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_stim_row frame_row(input logic [3:0] avail, input logic ce);
        t_stim_row r;
        r                        = '0;
        r.kind                   = ROW_FRAME;
        r.req.available_channels = avail;
        r.req.chunk_end          = ce;
        return r;
    endfunction

    // Single-result frame whose outcome is typed in directly.
    function automatic t_stim_row fixed_row(input logic [3:0] avail, input logic ce,
                                            input logic [1:0] st, input logic [23:0] smp);
        t_stim_row r;
        r                    = frame_row(avail, ce);
        r.fixed              = 1'b1;
        r.want.status        = st;
        r.want.sample        = smp;
        r.want.last_of_frame = 1'b1;
        r.want.end_of_chunk  = ce;
        return r;
    endfunction

    t_stim_row directed_rows [$] = '{
        frame_row(4'd2, 1'b0),
        fixed_row(4'd1, 1'b1, STAT_FEW, 24'd0),
        fixed_row(4'd0, 1'b0, STAT_FEW, 24'd0),
        write_row(CFG_PAUSED, 32'd1),
        fixed_row(4'd15, 1'b1, STAT_PAUSED, 24'd0),
        fixed_row(4'd1, 1'b0, STAT_FEW, 24'd0),
        write_row(CFG_PAUSED, 32'd0),
        write_row(CFG_COUNT, 32'd1),
        write_row(CFG_MODE, 32'(MODE_SQUARE)),
        write_row(CFG_STEP, 32'h8000_0000),
        fixed_row(4'd1, 1'b1, STAT_OK, 24'h7F_FFFF),
        fixed_row(4'd8, 1'b0, STAT_OK, 24'h80_0000),
        write_row(CFG_AMP, 32'h00FF_FFFF),
        fixed_row(4'd1, 1'b0, STAT_OK, 24'h7F_FFFF),
        fixed_row(4'd1, 1'b1, STAT_OK, 24'h80_0000),
        write_row(CFG_AMP, 32'd0),
        fixed_row(4'd1, 1'b0, STAT_OK, 24'd0),
        write_row(CFG_MODE, 32'(MODE_SINE)),
        write_row(CFG_STEP, 32'h0040_0000),
        write_row(CFG_AMP, 32'h0080_0000),
        write_row(CFG_COUNT, 32'd8),
        frame_row(4'd8, 1'b0),
        write_row(CFG_STEP, 32'h4000_0000),
        write_row(CFG_COUNT, 32'd3),
        frame_row(4'd3, 1'b0),
        frame_row(4'd3, 1'b1),
        frame_row(4'd4, 1'b0),
        frame_row(4'd9, 1'b0),
        write_row(CFG_COUNT, 32'd0),
        fixed_row(4'd0, 1'b1, STAT_FEW, 24'd0),
        frame_row(4'd1, 1'b1),
        write_row(CFG_COUNT, 32'd15),
        fixed_row(4'd7, 1'b0, STAT_FEW, 24'd0),
        write_row(CFG_MODE, 32'(MODE_NOISE)),
        write_row(CFG_SEED, 32'hFFFF_FFFF),
        write_row(CFG_AMP, 32'h00FF_FFFF),
        frame_row(4'd15, 1'b1),
        write_row(CFG_SEED, 32'd0),
        write_row(CFG_AMP, 32'h0080_0000),
        write_row(CFG_COUNT, 32'd9),
        frame_row(4'd8, 1'b0),
        write_row(CFG_UNUSED_LO, 32'hFFFF_FFFF),
        write_row(CFG_UNUSED_HI, 32'h0000_0000),
        write_row(CFG_MODE, 32'(MODE_SILENCE)),
        frame_row(4'd8, 1'b1),
        write_row(CFG_MODE, 32'hFFFF_FFFD),
        write_row(CFG_COUNT, 32'd1),
        write_row(CFG_STEP, 32'hFFFF_FFFF),
        frame_row(4'd1, 1'b0),
        frame_row(4'd1, 1'b1)
    };

    function automatic logic signed [23:0] clip24(input longint v);
        if (v > SAMPLE_MAX) begin
            return 24'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return 24'(SAMPLE_MIN);
        end
        return 24'(v);
    endfunction

    function automatic int active_channels();
        if (gen_count == 0) begin
            return 1;
        end
        if (gen_count > MAX_CHANNELS) begin
            return MAX_CHANNELS;
        end
        return int'(gen_count);
    endfunction

    // Fills the bits above a narrow register with junk now and then.
    function automatic logic [31:0] pad_high(input logic [31:0] v, input int w);
        if ($urandom_range(3) == 0) begin
            return (($urandom >> w) << w) | v;
        end
        return v;
    endfunction

    // Works out the results of one accepted frame request and queues them.
    task automatic predict_frame(input t_in req, output int n_new);
        int                 n;
        t_out               res;
        logic signed [23:0] tone;
        logic [IDX_W-1:0]   idx;
        logic [TI_W-1:0]    ti;
        longint             mag;
        longint             centered;
        n     = active_channels();
        res   = '0;
        tone  = '0;
        n_new = 0;
        if (req.available_channels < n || gen_paused) begin
            res.status        = (req.available_channels < n) ? STAT_FEW : STAT_PAUSED;
            res.last_of_frame = 1'b1;
            res.end_of_chunk  = req.chunk_end;
            expected_results.push_back(res);
            n_new = 1;
        end else begin
            if (gen_mode == MODE_SINE) begin
                idx  = phase_acc[31 -: IDX_W];
                // Odd quadrants run the quarter table backwards, the upper half negates.
                ti   = idx[QTR_W] ? TI_W'(QUARTER) - TI_W'(idx[QTR_W-1:0])
                                  : TI_W'(idx[QTR_W-1:0]);
                mag  = (longint'(quarter_sine[ti]) * longint'(gen_amp)
                        + (longint'(1) <<< 22)) >>> 23;
                tone = clip24(idx[IDX_W-1] ? -mag : mag);
            end else if (gen_mode == MODE_SQUARE) begin
                tone = clip24(phase_acc[31] ? -longint'(gen_amp) : longint'(gen_amp));
            end
            for (int c = 0; c < n; c++) begin
                res.status        = STAT_OK;
                res.channel       = c[2:0];
                res.last_of_frame = (c == n - 1);
                res.end_of_chunk  = (c == n - 1) && req.chunk_end;
                if (gen_mode == MODE_NOISE) begin
                    noise_state = noise_state * LCG_MUL + LCG_INC;
                    centered    = 2 * longint'(noise_state[30:16]) - NOISE_SPAN;
                    mag         = ((centered < 0 ? -centered : centered) * longint'(gen_amp)
                                   + NOISE_ROUND) / NOISE_SPAN;
                    res.sample  = clip24(centered < 0 ? -mag : mag);
                end else begin
                    res.sample = tone;
                end
                expected_results.push_back(res);
            end
            n_new = n;
            if (gen_mode == MODE_SINE || gen_mode == MODE_SQUARE) begin
                phase_acc = phase_acc + gen_step;
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:   gen_mode   = t_mode'(val[1:0]);
            CFG_STEP:   gen_step   = val;
            CFG_AMP:    gen_amp    = val[23:0];
            CFG_COUNT:  gen_count  = val[3:0];
            CFG_PAUSED: gen_paused = val[0];
            CFG_SEED:   noise_state = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering items and waits until every queued result has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_frame(input t_in req, input int gap, output int n_new);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_frame(req, n_new);
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin : build_sine
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned pwr;
        longint          acc;
        for (int i = 0; i <= QUARTER; i++) begin
            ang    = (longint'(i) * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
            ang_sq = (ang * ang) >> 30;
            pwr    = ang;
            acc    = longint'(ang);
            // Taylor series of the sine up to the thirteenth power.
            for (int k = 1; k <= 6; k++) begin
                pwr = (pwr * ang_sq) >> 30;
                pwr = pwr / longint'((2 * k) * (2 * k + 1));
                acc = k[0] ? acc - longint'(pwr) : acc + longint'(pwr);
            end
            if (acc < 0) begin
                acc = 0;
            end
            quarter_sine[i] = 32'((acc + 64) >>> 7);
        end
    end

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item: status %0d sample %0d channel %0d last %0b end %0b",
                         $time, o_out_data.status, o_out_data.sample, o_out_data.channel,
                         o_out_data.last_of_frame, o_out_data.end_of_chunk);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status || o_out_data.sample !== want.sample ||
                    o_out_data.channel !== want.channel ||
                    o_out_data.last_of_frame !== want.last_of_frame ||
                    o_out_data.end_of_chunk !== want.end_of_chunk) begin
                    mismatches++;
                    $display("%0t: expected status %0d sample %0d channel %0d last %0b end %0b",
                             $time, want.status, want.sample, want.channel,
                             want.last_of_frame, want.end_of_chunk);
                    $display("%0t: actual   status %0d sample %0d channel %0d last %0b end %0b",
                             $time, o_out_data.status, o_out_data.sample, o_out_data.channel,
                             o_out_data.last_of_frame, o_out_data.end_of_chunk);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_stim_row   row;
        t_in         req;
        int          n_new;
        int          gap;
        int          eff;
        logic [31:0] val;
        gen_mode    = MODE_SILENCE;
        gen_step    = '0;
        gen_amp     = 24'h80_0000;
        gen_count   = 4'd2;
        gen_paused  = 1'b0;
        phase_acc   = '0;
        noise_state = NOISE_SEED_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                drain();
                write_reg(row.idx, row.val);
            end else begin
                send_frame(row.req, 0, n_new);
                if (row.fixed) begin
                    repeat (n_new) void'(expected_results.pop_back());
                    expected_results.push_back(row.want);
                end
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            idle_pct  = IDLE_PCT[ph % 4];
            stall_pct = STALL_PCT[ph % 4];
            write_reg(CFG_MODE, pad_high(32'($urandom_range(3)), 2));
            case ($urandom_range(4))
                0:       val = 32'd0;
                1:       val = 32'hFFFF_FFFF;
                2:       val = $urandom_range(32'h00FF_FFFF);
                default: val = $urandom;
            endcase
            write_reg(CFG_STEP, val);
            case ($urandom_range(5))
                0:       val = 32'd0;
                1:       val = 32'h0080_0000;
                2:       val = 32'h00FF_FFFF;
                3:       val = $urandom_range(32'h0080_0000);
                default: val = $urandom & 32'h00FF_FFFF;
            endcase
            write_reg(CFG_AMP, pad_high(val, 24));
            val = ($urandom_range(99) < 80) ? $urandom_range(MAX_CHANNELS, 1) : $urandom_range(15);
            write_reg(CFG_COUNT, pad_high(val, 4));
            write_reg(CFG_PAUSED, pad_high(32'($urandom_range(99) < 15), 1));
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(3))
                    0:       val = 32'd0;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                write_reg(CFG_SEED, val);
            end
            eff = active_channels();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Hold the receiver off while items keep coming so the request queue fills.
                if (ph == 0 && k == 10) begin
                    long_hold_req = 1'b1;
                end
                if ((ph == 1 && k == 20) || $urandom_range(99) < 2) begin
                    drain();
                end
                if ($urandom_range(99) < 80) begin
                    req.available_channels = 4'($urandom_range(15, eff));
                end else begin
                    req.available_channels = 4'($urandom_range(15));
                end
                req.chunk_end = 1'($urandom_range(1));
                gap = 0;
                while (gap < 30 && $urandom_range(99) < idle_pct) begin
                    gap++;
                end
                send_frame(req, gap, n_new);
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ttng_pkg.sv
hw/rtl/ttng_queue.sv
hw/rtl/ttng_front.sv
hw/rtl/ttng_back.sv
hw/rtl/test_tone_noise_generator.sv
test/test_tone_noise_generator_test.sv
